// File: src/assert_macros.svh
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/cjti_pkg.sv
// Types and constants shared by the cubic joint trajectory interpolator.
package cjti_pkg;

  localparam int POS_W = 32;
  localparam int MAG_W = POS_W + 1;
  localparam int Q_W = 25;
  localparam int MUL_A_W = MAG_W;
  localparam int MUL_B_W = Q_W;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int G_W = 35;
  localparam int IDX_W = 21;
  localparam logic [Q_W-1:0] Q_ONE = 25'h1000000;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_STEP = 2'd2;

  localparam logic [2:0] CFG_TAU_STEP = 3'd0;
  localparam logic [2:0] CFG_INV_DURATION = 3'd1;
  localparam logic [2:0] CFG_TIME_STEP = 3'd2;
  localparam logic [2:0] CFG_DURATION = 3'd3;
  localparam logic [2:0] CFG_POINT_COUNT = 3'd4;

  typedef enum logic [3:0] {
    OP_TAU,
    OP_TIME,
    OP_T2,
    OP_T3,
    OP_P,
    OP_G,
    OP_POS,
    OP_VLO,
    OP_VHI
  } op_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic mul;
    logic wb;
    logic emit;
    logic last;
    op_t  op;
  } ctl_cmd_t;

  typedef struct packed {
    logic active;
  } dp_status_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [2:0]              joint_select;
    logic signed [POS_W-1:0] start_position;
    logic signed [POS_W-1:0] goal_position;
  } item_t;

  typedef struct packed {
    logic [2:0]              joint_index;
    logic [26:0]             sample_time_us;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] velocity;
    logic [POS_W-2:0]        peak_speed;
    logic                    last_joint;
    logic                    final_sample;
  } result_t;

endpackage

// File: src/cjti_ctrl.sv
// Controller state machine that sequences the shared multiplier over one sample.
module cjti_ctrl #(
  parameter int JOINTS = 6,
  parameter int JW = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           command,
  input  cjti_pkg::dp_status_t status,
  output logic                 busy,
  output cjti_pkg::ctl_cmd_t   cmd,
  output logic [JW-1:0]        jcnt
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_WB   = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t          state, state_next;
  cjti_pkg::op_t   op, op_next;
  logic [JW-1:0]   jcnt_q;
  logic [JW-1:0]   jcnt_next;
  logic            accept;
  logic            last;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign last = (jcnt == JW'(JOINTS - 1));
  assign jcnt = jcnt_q;

  always_comb begin
    state_next = state;
    op_next = op;
    jcnt_next = jcnt_q;
    case (state)
      ST_IDLE: begin
        if (accept && command == cjti_pkg::CMD_STEP && status.active) begin
          state_next = ST_MUL;
          op_next = cjti_pkg::OP_TAU;
          jcnt_next = '0;
        end
      end
      ST_MUL: begin
        state_next = ST_WB;
      end
      ST_WB: begin
        state_next = ST_MUL;
        case (op)
          cjti_pkg::OP_TAU:  op_next = cjti_pkg::OP_TIME;
          cjti_pkg::OP_TIME: op_next = cjti_pkg::OP_T2;
          cjti_pkg::OP_T2:   op_next = cjti_pkg::OP_T3;
          cjti_pkg::OP_T3:   op_next = cjti_pkg::OP_P;
          cjti_pkg::OP_P:    op_next = cjti_pkg::OP_G;
          cjti_pkg::OP_G:    op_next = cjti_pkg::OP_POS;
          cjti_pkg::OP_POS:  op_next = cjti_pkg::OP_VLO;
          cjti_pkg::OP_VLO:  op_next = cjti_pkg::OP_VHI;
          default:           state_next = ST_EMIT;
        endcase
      end
      ST_EMIT: begin
        if (last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MUL;
          op_next = cjti_pkg::OP_POS;
          jcnt_next = jcnt_q + JW'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= cjti_pkg::OP_TAU;
      jcnt_q <= '0;
    end else begin
      state <= state_next;
      op <= op_next;
      jcnt_q <= jcnt_next;
    end
  end

  always_comb begin
    cmd.load = accept && command == cjti_pkg::CMD_LOAD;
    cmd.restart = accept && command == cjti_pkg::CMD_RESTART;
    cmd.mul = (state == ST_MUL);
    cmd.wb = (state == ST_WB);
    cmd.emit = (state == ST_EMIT);
    cmd.last = last;
    cmd.op = op;
  end

endmodule

// File: src/cjti_dp.sv
// Datapath with registers, endpoint tables and one shared multiplier.
module cjti_dp #(
  parameter int JOINTS = 6,
  parameter int JW = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cjti_pkg::ctl_cmd_t   cmd,
  input  logic [JW-1:0]        jcnt,
  input  cjti_pkg::item_t      item,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [26:0]          cfg_data,
  output cjti_pkg::dp_status_t status,
  output cjti_pkg::result_t    result,
  output logic                 result_valid
);

  localparam int PW = cjti_pkg::POS_W;
  localparam int AW = cjti_pkg::MUL_A_W;
  localparam int BW = cjti_pkg::MUL_B_W;
  localparam int RW = cjti_pkg::PROD_W;
  localparam int QW = cjti_pkg::Q_W;
  localparam int MW = cjti_pkg::MAG_W;
  localparam int GW = cjti_pkg::G_W;
  localparam int SW = PW + 3;
  localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  logic [24:0] tau_step;
  logic [24:0] inverse_duration;
  logic [19:0] time_step_us;
  logic [26:0] duration_us;
  logic [20:0] point_count;

  logic signed [PW-1:0] start_table [JOINTS];
  logic signed [PW-1:0] goal_table [JOINTS];
  logic [cjti_pkg::IDX_W-1:0] sample_index;
  logic [PW-2:0] peak_speed;

  logic [QW-1:0] tau, t2, s, p;
  logic [26:0] t_us;
  logic [GW-1:0] g;
  logic [PW-1:0] pos;
  logic [RW-1:0] vacc;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [RW-1:0] prod;

  logic [RW-1:0] rnd24, rnd16;
  logic [RW-25:0] q24;
  logic [QW-1:0] p6, t3_new, s_new;
  logic [26:0] t2x3, t3x2, sdiff;
  logic signed [PW-1:0] st_j, gl_j;
  logic [MW-1:0] d, mag;
  logic neg;
  logic [SW-1:0] r_ext, pos_sum;
  logic vbig;
  logic [PW-2:0] speed, peak_next;
  logic [PW-1:0] vel;
  logic final_s;

  assign st_j = start_table[jcnt];
  assign gl_j = goal_table[jcnt];
  assign d = {gl_j[PW-1], gl_j} - {st_j[PW-1], st_j};
  assign neg = d[MW-1];
  assign mag = neg ? -d : d;
  assign p6 = QW'({p, 2'b00}) + QW'({p, 1'b0});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      cjti_pkg::OP_TAU: begin
        mul_a = AW'(sample_index);
        mul_b = tau_step;
      end
      cjti_pkg::OP_TIME: begin
        mul_a = AW'(sample_index);
        mul_b = BW'(time_step_us);
      end
      cjti_pkg::OP_T2: begin
        mul_a = AW'(tau);
        mul_b = tau;
      end
      cjti_pkg::OP_T3: begin
        mul_a = AW'(t2);
        mul_b = tau;
      end
      cjti_pkg::OP_P: begin
        mul_a = AW'(tau);
        mul_b = cjti_pkg::Q_ONE - tau;
      end
      cjti_pkg::OP_G: begin
        mul_a = AW'(p6);
        mul_b = inverse_duration;
      end
      cjti_pkg::OP_POS: begin
        mul_a = mag;
        mul_b = s;
      end
      cjti_pkg::OP_VLO: begin
        mul_a = mag;
        mul_b = BW'(g[23:0]);
      end
      cjti_pkg::OP_VHI: begin
        mul_a = mag;
        mul_b = BW'(g[GW-1:24]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd24 = prod + RW'(1 << 23);
  assign rnd16 = prod + RW'(1 << 15);
  assign q24 = rnd24[RW-1:24];
  assign t3_new = q24[QW-1:0];
  assign t2x3 = 27'(t2) + 27'({t2, 1'b0});
  assign t3x2 = 27'({t3_new, 1'b0});
  assign sdiff = t2x3 - t3x2;
  assign s_new = (t3x2 > t2x3) ? '0 :
                 (sdiff > 27'(cjti_pkg::Q_ONE)) ? cjti_pkg::Q_ONE : sdiff[QW-1:0];
  assign r_ext = SW'(q24);
  assign pos_sum = {{3{st_j[PW-1]}}, st_j} + (neg ? -r_ext : r_ext);

  assign vbig = vacc > RW'(POS_MAX);
  assign speed = vbig ? POS_MAX[PW-2:0] : vacc[PW-2:0];
  assign vel = neg ? (vbig ? POS_MIN : -vacc[PW-1:0]) : (vbig ? POS_MAX : vacc[PW-1:0]);
  assign peak_next = (speed > peak_speed) ? speed : peak_speed;
  assign final_s = ({1'b0, sample_index} + 22'd1) == {1'b0, point_count};
  assign status.active = sample_index < point_count;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= RW'(mul_a) * RW'(mul_b);
    end
    if (cmd.wb) begin
      case (cmd.op)
        cjti_pkg::OP_TAU:
          tau <= (prod > RW'(cjti_pkg::Q_ONE)) ? cjti_pkg::Q_ONE : prod[QW-1:0];
        cjti_pkg::OP_TIME:
          t_us <= (prod > RW'(duration_us)) ? duration_us : prod[26:0];
        cjti_pkg::OP_T2: t2 <= q24[QW-1:0];
        cjti_pkg::OP_T3: s <= s_new;
        cjti_pkg::OP_P: p <= q24[QW-1:0];
        cjti_pkg::OP_G: g <= rnd16[16 +: GW];
        cjti_pkg::OP_POS: pos <= pos_sum[PW-1:0];
        cjti_pkg::OP_VLO: vacc <= RW'(q24);
        cjti_pkg::OP_VHI: vacc <= vacc + prod;
        default: vacc <= vacc;
      endcase
    end
    if (cmd.emit) begin
      result.joint_index <= 3'(jcnt);
      result.sample_time_us <= t_us;
      result.position <= pos;
      result.velocity <= vel;
      result.peak_speed <= peak_next;
      result.last_joint <= cmd.last;
      result.final_sample <= final_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tau_step <= 25'd16777;
      inverse_duration <= 25'd65536;
      time_step_us <= 20'd1000;
      duration_us <= 27'd1000000;
      point_count <= 21'd1001;
      sample_index <= '0;
      peak_speed <= '0;
      result_valid <= 1'b0;
      for (int j = 0; j < JOINTS; j++) begin
        start_table[j] <= '0;
        goal_table[j] <= '0;
      end
    end else begin
      result_valid <= cmd.emit;
      if (cfg_valid) begin
        case (cfg_index)
          cjti_pkg::CFG_TAU_STEP:     tau_step <= cfg_data[24:0];
          cjti_pkg::CFG_INV_DURATION: inverse_duration <= cfg_data[24:0];
          cjti_pkg::CFG_TIME_STEP:    time_step_us <= cfg_data[19:0];
          cjti_pkg::CFG_DURATION:     duration_us <= cfg_data;
          cjti_pkg::CFG_POINT_COUNT:  point_count <= cfg_data[20:0];
          default:                    point_count <= point_count;
        endcase
      end
      if (cmd.load && {1'b0, item.joint_select} < 4'(JOINTS)) begin
        start_table[item.joint_select[JW-1:0]] <= item.start_position;
        goal_table[item.joint_select[JW-1:0]] <= item.goal_position;
      end
      if (cmd.restart) begin
        sample_index <= '0;
        peak_speed <= '0;
      end
      if (cmd.emit) begin
        peak_speed <= peak_next;
        if (cmd.last) begin
          sample_index <= sample_index + 21'd1;
        end
      end
    end
  end

endmodule

// File: src/cubic_joint_trajectory_interpolator.sv
// Cubic joint trajectory interpolator: one step command yields one result per joint.
// Steps are accepted only while idle: a shared 33x25 multiplier forms each product in a
// multiply state and a write-back state (six per sample, three per joint). Results
// follow in joint order, each registered in an emit state after its joint's products.
// Load, restart and steps past the last point finish in the accepting cycle.
// Synchronous active-high reset restores register defaults and clears tables and index.
`include "assert_macros.svh"

module cubic_joint_trajectory_interpolator #(
  parameter int JOINTS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cjti_pkg::item_t    item,
  output cjti_pkg::result_t  result,
  output logic               result_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [26:0]        cfg_data
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  cjti_pkg::ctl_cmd_t   cmd;
  cjti_pkg::dp_status_t status;
  logic [JW-1:0]        jcnt;
  logic                 step_go;
  logic                 joint_ok;

  assign cfg_ready = 1'b1;

  cjti_ctrl #(.JOINTS(JOINTS), .JW(JW)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .command(item.command),
    .status(status),
    .busy(busy),
    .cmd(cmd),
    .jcnt(jcnt)
  );

  cjti_dp #(.JOINTS(JOINTS), .JW(JW)) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .jcnt(jcnt),
    .item(item),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .status(status),
    .result(result),
    .result_valid(result_valid)
  );

  assign step_go = start && !busy && item.command == cjti_pkg::CMD_STEP && status.active;
  assign joint_ok = 32'(result.joint_index) < JOINTS;

  `ASSERT_NEXT(a_step_starts, clk, rst, step_go, busy)
  `ASSERT_SAME(a_last_idle, clk, rst, result_valid && result.last_joint, !busy)
  `ASSERT_SAME(a_more_follow, clk, rst, result_valid && !result.last_joint, busy)
  `ASSERT_SAME(a_joint_range, clk, rst, result_valid, joint_ok)

endmodule

// File: sim/tb.sv
// Self-checking testbench for the cubic joint trajectory interpolator.
module tb;

  localparam int NJ = 6;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [2:0] CFG_BAD_LO = 3'd5;
  localparam logic [2:0] CFG_BAD_HI = 3'd7;
  localparam longint unsigned ONE24 = 64'd1 << 24;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  sel;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
  } row_t;

  logic clk, rst, start, busy, result_valid, cfg_valid, cfg_ready;
  cjti_pkg::item_t item;
  cjti_pkg::result_t result;
  logic [2:0] cfg_index;
  logic [26:0] cfg_data;

  cubic_joint_trajectory_interpolator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .result(result),
    .result_valid(result_valid), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  longint unsigned tau_step, inv_duration, time_step, duration, point_count;
  longint start_pos [NJ];
  longint goal_pos [NJ];
  longint unsigned sample_idx, peak_speed;
  cjti_pkg::result_t pending_results[$];
  int mismatches;
  int idle_cycles;
  int burst_left;
  row_t rows [20];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint scaled_q24(longint d, longint unsigned q);
    longint unsigned mag, r;
    mag = (d < 0) ? longint'(-d) : d;
    r = (mag >> 24) * q + (((mag & (ONE24 - 1)) * q + (64'd1 << 23)) >> 24);
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  task automatic predict_item(cjti_pkg::item_t it, bit typed);
    longint unsigned tau, t2, t3, s, p, g, t_us;
    longint sv, d, pos, vel;
    longint unsigned speed;
    cjti_pkg::result_t r;
    case (it.command)
      cjti_pkg::CMD_LOAD: begin
        if (it.joint_select < NJ) begin
          start_pos[it.joint_select] = longint'(it.start_position);
          goal_pos[it.joint_select] = longint'(it.goal_position);
        end
      end
      cjti_pkg::CMD_RESTART: begin
        sample_idx = 0;
        peak_speed = 0;
      end
      cjti_pkg::CMD_STEP: begin
        if (sample_idx < point_count) begin
          tau = sample_idx * tau_step;
          if (tau > ONE24) tau = ONE24;
          t_us = sample_idx * time_step;
          if (t_us > duration) t_us = duration;
          t2 = (tau * tau + (64'd1 << 23)) >> 24;
          t3 = (t2 * tau + (64'd1 << 23)) >> 24;
          sv = 3 * longint'(t2) - 2 * longint'(t3);
          if (sv < 0) sv = 0;
          if (sv > longint'(ONE24)) sv = ONE24;
          s = sv;
          p = (tau * (ONE24 - tau) + (64'd1 << 23)) >> 24;
          g = (6 * p * inv_duration + (64'd1 << 15)) >> 16;
          for (int j = 0; j < NJ; j++) begin
            d = goal_pos[j] - start_pos[j];
            pos = start_pos[j] + scaled_q24(d, s);
            vel = scaled_q24(d, g);
            if (vel > POS_MAX) vel = POS_MAX;
            if (vel < POS_MIN) vel = POS_MIN;
            speed = (vel < 0) ? longint'(-vel) : vel;
            if (speed > POS_MAX) speed = POS_MAX;
            if (speed > peak_speed) peak_speed = speed;
            r.joint_index = 3'(j);
            r.sample_time_us = t_us[26:0];
            r.position = pos[31:0];
            r.velocity = vel[31:0];
            r.peak_speed = peak_speed[30:0];
            r.last_joint = (j == NJ - 1);
            r.final_sample = (sample_idx + 1 == point_count);
            if (typed) begin
              // Empty tables at the first sample: everything is zero.
              r = '0;
              r.joint_index = 3'(j);
              r.last_joint = (j == NJ - 1);
            end
            pending_results = {pending_results, r};
          end
          sample_idx = (sample_idx + 1) & 64'h1FFFFF;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(cjti_pkg::item_t it, bit typed);
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predict_item(it, typed);
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [26:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cjti_pkg::CFG_TAU_STEP: tau_step = value[24:0];
      cjti_pkg::CFG_INV_DURATION: inv_duration = value[24:0];
      cjti_pkg::CFG_TIME_STEP: time_step = value[19:0];
      cjti_pkg::CFG_DURATION: duration = value;
      cjti_pkg::CFG_POINT_COUNT: point_count = value[20:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(longint unsigned ts, longint unsigned inv, longint unsigned dt,
                           longint unsigned dur, longint unsigned pc);
    write_reg(cjti_pkg::CFG_TAU_STEP, 27'(ts));
    write_reg(cjti_pkg::CFG_INV_DURATION, 27'(inv));
    write_reg(cjti_pkg::CFG_TIME_STEP, 27'(dt));
    write_reg(cjti_pkg::CFG_DURATION, 27'(dur));
    write_reg(cjti_pkg::CFG_POINT_COUNT, 27'(pc));
    write_reg(3'($urandom_range(CFG_BAD_LO, CFG_BAD_HI)), 27'($urandom));
  endtask

  function automatic logic [31:0] pick_position();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(int count);
    cjti_pkg::item_t it;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      it.joint_select = (r % 9 == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      it.start_position = pick_position();
      it.goal_position = pick_position();
      if (r < 45) it.command = cjti_pkg::CMD_STEP;
      else if (r < 80) it.command = cjti_pkg::CMD_LOAD;
      else if (r < 92) it.command = cjti_pkg::CMD_RESTART;
      else it.command = CMD_NONE;
      send_item(it, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        cjti_pkg::result_t want;
        want = pending_results.pop_front();
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    cjti_pkg::item_t it;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 8;
    tau_step = 16777;
    inv_duration = 65536;
    time_step = 1000;
    duration = 1000000;
    point_count = 1001;
    sample_idx = 0;
    peak_speed = 0;
    for (int j = 0; j < NJ; j++) begin
      start_pos[j] = 0;
      goal_pos[j] = 0;
    end
    rows = '{
      '{cjti_pkg::CMD_STEP, 3'd0, 32'h0, 32'h0, 1'b1},
      '{cjti_pkg::CMD_LOAD, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
      '{cjti_pkg::CMD_LOAD, 3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0},
      '{cjti_pkg::CMD_LOAD, 3'd2, 32'h0, 32'h7FFF_FFFF, 1'b0},
      '{cjti_pkg::CMD_LOAD, 3'd3, 32'hFFFF_FFFF, 32'h0010_0000, 1'b0},
      '{cjti_pkg::CMD_LOAD, 3'd4, 32'h1234_5678, 32'h1234_5678, 1'b0},
      '{cjti_pkg::CMD_LOAD, 3'd5, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0},
      '{cjti_pkg::CMD_LOAD, 3'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0},
      '{cjti_pkg::CMD_LOAD, 3'd7, 32'h8000_0000, 32'h8000_0000, 1'b0},
      '{CMD_NONE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
      '{cjti_pkg::CMD_STEP, 3'd0, 32'h0, 32'h0, 1'b0},
      '{cjti_pkg::CMD_STEP, 3'd0, 32'h0, 32'h0, 1'b0},
      '{cjti_pkg::CMD_STEP, 3'd0, 32'h0, 32'h0, 1'b0},
      '{cjti_pkg::CMD_RESTART, 3'd0, 32'h0, 32'h0, 1'b0},
      '{cjti_pkg::CMD_STEP, 3'd0, 32'h0, 32'h0, 1'b0},
      '{cjti_pkg::CMD_LOAD, 3'd0, 32'hFFF0_0000, 32'h0010_0000, 1'b0},
      '{cjti_pkg::CMD_STEP, 3'd0, 32'h0, 32'h0, 1'b0},
      '{cjti_pkg::CMD_RESTART, 3'd0, 32'h0, 32'h0, 1'b0},
      '{cjti_pkg::CMD_STEP, 3'd0, 32'h0, 32'h0, 1'b0},
      '{cjti_pkg::CMD_STEP, 3'd0, 32'h0, 32'h0, 1'b0}
    };
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      it.command = rows[k].cmd;
      it.joint_select = rows[k].sel;
      it.start_position = rows[k].a;
      it.goal_position = rows[k].b;
      send_item(it, rows[k].typed);
    end

    wait_idle();
    configure(64'd2097152, 64'd524288, 64'd125000, 64'd1000000, 64'd9);
    random_items(40);
    wait_idle();
    configure(64'd0, 64'h1FF_FFFF, 64'hF_FFFF, 64'd0, 64'd3);
    random_items(25);
    wait_idle();
    configure(64'h1FF_FFFF, 64'd1, 64'd1, 64'h7FF_FFFF, 64'd2);
    random_items(25);
    wait_idle();
    configure(64'd1000000, 64'h100_0000, 64'd77, 64'd500, 64'd1);
    random_items(20);
    wait_idle();
    configure(64'd3000000, 64'd1000000, 64'd400, 64'd2000, 64'd0);
    random_items(15);
    wait_idle();
    configure($urandom_range(1, 1 << 24), $urandom_range(1, 1 << 24), $urandom_range(1, 1000000),
              $urandom_range(0, 100000000), $urandom_range(1, 12));
    random_items(35);

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: cubic_joint_trajectory_interpolator.f
+incdir+src
src/cjti_pkg.sv
src/cjti_ctrl.sv
src/cjti_dp.sv
src/cubic_joint_trajectory_interpolator.sv
sim/tb.sv
